### rtl/core/http_response_body_framer_unit_macros.svh
// Assertion helpers, compiled out when SYNTH is defined
`ifndef HTTP_RESPONSE_BODY_FRAMER_UNIT_MACROS_SVH
`define HTTP_RESPONSE_BODY_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTH
`define HRBF_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hrbf assertion failed");
`define HRBF_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hrbf assertion failed");
`else
`define HRBF_ASSERT_IMP(lbl, pre, post)
`define HRBF_ASSERT_NXT(lbl, pre, post)
`endif

`endif

### rtl/core/hrbf_pkg.sv
package hrbf_pkg;

	localparam int BUFFER_DEPTH = 1024;
	localparam int POS_W = $clog2(BUFFER_DEPTH);
	localparam int ACC_W = 16;
	localparam int WIN_N = 7;

	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LH    = 8'h68;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_STATUS  = 3'd1;
	localparam logic [2:0] PH_HEADERS = 3'd2;
	localparam logic [2:0] PH_DIGITS  = 3'd3;
	localparam logic [2:0] PH_BODY    = 3'd4;

	typedef struct packed {
		logic http_hit;
		logic status_ok;
		logic length_hit;
		logic blank_hit;
	} match_t;

	// Packed so that the first field sits in the highest bits
	typedef struct packed {
		logic [1:0]       pad;
		logic [ACC_W-1:0] content_length;
		logic             message_bad_length;
		logic             message_good;
		logic [7:0]       body_data;
		logic             body_valid;
		logic [2:0]       parse_phase;
	} result_t;

endpackage

### rtl/core/hrbf_window.sv
module hrbf_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         rx_byte,
	output hrbf_pkg::match_t   match
);

	// win_q[0] is the previous byte, win_q[6] the oldest kept
	logic [7:0] win_q [hrbf_pkg::WIN_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hrbf_pkg::WIN_N; i++) begin
				win_q[i] <= 8'h00;
			end
		end else if (adv) begin
			win_q[0] <= rx_byte;
			for (int i = 1; i < hrbf_pkg::WIN_N; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_comb begin
		match.http_hit   = (rx_byte == hrbf_pkg::CH_P) && (win_q[0] == hrbf_pkg::CH_T) &&
			(win_q[1] == hrbf_pkg::CH_T) && (win_q[2] == hrbf_pkg::CH_H);
		match.status_ok  = (win_q[1] == hrbf_pkg::CH_2) && (win_q[0] == hrbf_pkg::CH_0);
		match.length_hit = (rx_byte == hrbf_pkg::CH_SPACE) && (win_q[0] == hrbf_pkg::CH_COLON) &&
			(win_q[1] == hrbf_pkg::CH_LH) && (win_q[2] == hrbf_pkg::CH_LT) &&
			(win_q[3] == hrbf_pkg::CH_G) && (win_q[4] == hrbf_pkg::CH_N) &&
			(win_q[5] == hrbf_pkg::CH_E) && (win_q[6] == hrbf_pkg::CH_L);
		match.blank_hit  = (rx_byte == hrbf_pkg::CH_LF) && (win_q[0] == hrbf_pkg::CH_CR) &&
			(win_q[1] == hrbf_pkg::CH_LF);
	end

endmodule

### rtl/core/hrbf_parser.sv
`include "http_response_body_framer_unit_macros.svh"

module hrbf_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         rx_byte,
	input  hrbf_pkg::match_t   match,
	output hrbf_pkg::result_t  result
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_STATUS  = 5'b00010,
		ST_HEADERS = 5'b00100,
		ST_DIGITS  = 5'b01000,
		ST_BODY    = 5'b10000
	} state_t;

	state_t                     st_q, st_d;
	logic [hrbf_pkg::POS_W-1:0] pos_q, pos_d, pos_inc;
	logic [hrbf_pkg::ACC_W-1:0] acc_q, acc_d;
	logic                       dig_q, dig_d;
	logic [hrbf_pkg::ACC_W+3:0] acc_mul;
	logic [hrbf_pkg::ACC_W+3:0] acc_sum;
	logic                       is_digit;
	logic                       valid, good, bad;
	logic [2:0]                 phase;

	always_comb begin
		pos_inc = (32'(pos_q) + 32'd1 >= 32'(hrbf_pkg::BUFFER_DEPTH)) ?
			'0 : pos_q + hrbf_pkg::POS_W'(1);
		is_digit = (rx_byte >= hrbf_pkg::CH_0) && (rx_byte <= hrbf_pkg::CH_9);
		acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		acc_sum  = acc_mul + (hrbf_pkg::ACC_W+4)'(rx_byte - hrbf_pkg::CH_0);

		st_d  = st_q;
		pos_d = pos_inc;
		acc_d = acc_q;
		dig_d = dig_q;
		valid = 1'b0;
		good  = 1'b0;
		bad   = 1'b0;

		unique case (st_q)
			ST_STATUS: begin
				if (match.http_hit) begin
					pos_d = '0;
				end else if (32'(pos_q) == 32'd7) begin
					if (match.status_ok) begin
						st_d  = ST_HEADERS;
						pos_d = '0;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_HEADERS: begin
				if (match.http_hit) begin
					st_d  = ST_STATUS;
					pos_d = '0;
				end else if ((32'(pos_q) > 32'd16) && match.length_hit) begin
					st_d  = ST_DIGITS;
					acc_d = '0;
					dig_d = 1'b1;
				end
			end
			ST_DIGITS: begin
				if (match.http_hit) begin
					st_d  = ST_STATUS;
					pos_d = '0;
				end else begin
					if (dig_q) begin
						if (is_digit) begin
							acc_d = (acc_sum > (hrbf_pkg::ACC_W+4)'({hrbf_pkg::ACC_W{1'b1}})) ?
								{hrbf_pkg::ACC_W{1'b1}} : acc_sum[hrbf_pkg::ACC_W-1:0];
						end else begin
							dig_d = 1'b0;
						end
					end
					if (match.blank_hit) begin
						st_d  = ST_BODY;
						pos_d = '0;
					end
				end
			end
			ST_BODY: begin
				if (match.http_hit) begin
					st_d  = ST_STATUS;
					pos_d = '0;
				end else begin
					valid = 1'b1;
					if (rx_byte == hrbf_pkg::CH_RBRACE) begin
						if (32'(pos_q) + 32'd1 == 32'(acc_q)) begin
							good = 1'b1;
						end else begin
							bad = 1'b1;
						end
						st_d = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
				if (match.http_hit) begin
					st_d  = ST_STATUS;
					pos_d = '0;
				end
			end
		endcase

		unique case (st_d)
			ST_STATUS:  phase = hrbf_pkg::PH_STATUS;
			ST_HEADERS: phase = hrbf_pkg::PH_HEADERS;
			ST_DIGITS:  phase = hrbf_pkg::PH_DIGITS;
			ST_BODY:    phase = hrbf_pkg::PH_BODY;
			default:    phase = hrbf_pkg::PH_IDLE;
		endcase

		result.pad                = 2'b00;
		result.content_length     = acc_d;
		result.message_bad_length = bad;
		result.message_good       = good;
		result.body_data          = valid ? rx_byte : 8'h00;
		result.body_valid         = valid;
		result.parse_phase        = phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			pos_q <= '0;
			acc_q <= '0;
			dig_q <= 1'b0;
		end else if (adv) begin
			st_q  <= st_d;
			pos_q <= pos_d;
			acc_q <= acc_d;
			dig_q <= dig_d;
		end
	end

	`HRBF_ASSERT_IMP(a_good_bad_excl, adv && good, !bad)
	`HRBF_ASSERT_IMP(a_good_needs_len, adv && good, acc_q != '0)
	`HRBF_ASSERT_NXT(a_http_pos_restart, adv && match.http_hit, pos_q == '0)

endmodule

### rtl/core/http_response_body_framer_unit.sv
// HTTP response body framer. Takes one received character per transfer on the
// s_ side and returns one result per character on the m_ side: the parse phase
// after that character, a body flag with the body byte, good/bad-length end of
// message flags on the closing brace, and the Content-Length value decoded so
// far. It accepts one character per clock cycle while s_tready is high; a result
// reaches the m_ side after its character passes the input register and then the
// result register, and s_tready drops only while both registers are full and
// m_tready is low.
// No configuration and no clearing pass: the block is ready out of reset.
`include "http_response_body_framer_unit_macros.svh"

module http_response_body_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [2:0] parse_phase, [3] body_valid, [11:4] body_data,
	                              // [12] message_good, [13] message_bad_length,
	                              // [29:14] content_length, [31:30] zero
);

	logic              valid_s1, valid_s2;
	logic [7:0]        byte_s1;
	hrbf_pkg::result_t result_s2;
	hrbf_pkg::result_t result;
	hrbf_pkg::match_t  match;
	logic              adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	hrbf_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rx_byte (byte_s1),
		.match   (match)
	);

	hrbf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rx_byte (byte_s1),
		.match   (match),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (adv) begin
			result_s2 <= result;
		end
	end

	`HRBF_ASSERT_NXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(byte_s1))
	`HRBF_ASSERT_NXT(a_s2_load, adv, valid_s2)
	`HRBF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

### dv/hrbf_checker.sv
`timescale 1ns / 1ps

module hrbf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [2:0] parse_phase, [3] body_valid, [11:4] body_data,
	                              // [12] message_good, [13] message_bad_length,
	                              // [29:14] content_length, [31:30] zero
	output int          mismatches,
	output int          pending
);

	localparam int STATUS_CHECK_POS = 7;
	localparam int MIN_MARKER_POS   = 16;

	logic [2:0]        phase;
	logic [7:0]        recent [8];
	int unsigned       position;
	logic [15:0]       clen_accum;
	logic              collecting;
	hrbf_pkg::result_t expected_results [$];
	int                fail_count;

	assign mismatches = fail_count;

	task automatic parse_byte(input logic [7:0] b, output hrbf_pkg::result_t r);
		int unsigned cur;
		int unsigned nxt;
		int          v;
		logic        http;
		logic        marker;
		logic        blank;
		logic        valid;
		logic        good;
		logic        bad;
		cur   = position;
		nxt   = (cur + 1 >= hrbf_pkg::BUFFER_DEPTH) ? 0 : cur + 1;
		valid = 1'b0;
		good  = 1'b0;
		bad   = 1'b0;
		for (int i = 7; i > 0; i--) begin
			recent[i] = recent[i-1];
		end
		recent[0] = b;
		http   = recent[3] == hrbf_pkg::CH_H && recent[2] == hrbf_pkg::CH_T &&
		         recent[1] == hrbf_pkg::CH_T && recent[0] == hrbf_pkg::CH_P;
		marker = recent[7] == hrbf_pkg::CH_L && recent[6] == hrbf_pkg::CH_E &&
		         recent[5] == hrbf_pkg::CH_N && recent[4] == hrbf_pkg::CH_G &&
		         recent[3] == hrbf_pkg::CH_LT && recent[2] == hrbf_pkg::CH_LH &&
		         recent[1] == hrbf_pkg::CH_COLON && recent[0] == hrbf_pkg::CH_SPACE;
		blank  = recent[2] == hrbf_pkg::CH_LF && recent[1] == hrbf_pkg::CH_CR &&
		         recent[0] == hrbf_pkg::CH_LF;
		case (phase)
			hrbf_pkg::PH_STATUS: begin
				if (http) begin
					nxt = 0;
				end else if (cur == STATUS_CHECK_POS) begin
					if (recent[2] == hrbf_pkg::CH_2 && recent[1] == hrbf_pkg::CH_0) begin
						phase = hrbf_pkg::PH_HEADERS;
						nxt   = 0;
					end else begin
						phase = hrbf_pkg::PH_IDLE;
					end
				end
			end
			hrbf_pkg::PH_HEADERS: begin
				if (http) begin
					phase = hrbf_pkg::PH_STATUS;
					nxt   = 0;
				end else if (cur > MIN_MARKER_POS && marker) begin
					phase      = hrbf_pkg::PH_DIGITS;
					clen_accum = '0;
					collecting = 1'b1;
				end
			end
			hrbf_pkg::PH_DIGITS: begin
				if (http) begin
					phase = hrbf_pkg::PH_STATUS;
					nxt   = 0;
				end else begin
					if (collecting) begin
						if (b >= hrbf_pkg::CH_0 && b <= hrbf_pkg::CH_9) begin
							v = int'(clen_accum) * 10 + int'(b) - int'(hrbf_pkg::CH_0);
							clen_accum = (v > 65535) ? 16'hFFFF : v[15:0];
						end else begin
							collecting = 1'b0;
						end
					end
					if (blank) begin
						phase = hrbf_pkg::PH_BODY;
						nxt   = 0;
					end
				end
			end
			hrbf_pkg::PH_BODY: begin
				if (http) begin
					phase = hrbf_pkg::PH_STATUS;
					nxt   = 0;
				end else begin
					valid = 1'b1;
					if (b == hrbf_pkg::CH_RBRACE) begin
						if (cur + 1 == int'(clen_accum))
							good = 1'b1;
						else
							bad = 1'b1;
						phase = hrbf_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				phase = hrbf_pkg::PH_IDLE;
				if (http) begin
					phase = hrbf_pkg::PH_STATUS;
					nxt   = 0;
				end
			end
		endcase
		position = nxt;
		r = '0;
		r.parse_phase        = phase;
		r.body_valid         = valid;
		r.body_data          = valid ? b : 8'h00;
		r.message_good       = good;
		r.message_bad_length = bad;
		r.content_length     = clen_accum;
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hrbf_pkg::result_t r;
		hrbf_pkg::result_t got;
		if (!arst_n) begin
			phase      = hrbf_pkg::PH_IDLE;
			position   = 0;
			clen_accum = '0;
			collecting = 1'b0;
			for (int i = 0; i < 8; i++) begin
				recent[i] = 8'h00;
			end
			expected_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, r);
				expected_results.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$error("result transfer with no byte outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					r = expected_results.pop_front();
					check_field("parse_phase", r.parse_phase, got.parse_phase);
					check_field("body_valid", r.body_valid, got.body_valid);
					check_field("body_data", r.body_data, got.body_data);
					check_field("message_good", r.message_good, got.message_good);
					check_field("message_bad_length", r.message_bad_length,
						got.message_bad_length);
					check_field("content_length", r.content_length, got.content_length);
					check_field("pad", 0, got.pad);
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int TARGET_BYTES = 550;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;
	int          mismatches;
	int          pending;

	logic [7:0]  tx_bytes [$];
	int          bytes_sent = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	http_response_body_framer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hrbf_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			tx_bytes.push_back(s[i]);
		end
	endtask

	task automatic add_crlf();
		tx_bytes.push_back(hrbf_pkg::CH_CR);
		tx_bytes.push_back(hrbf_pkg::CH_LF);
	endtask

	task automatic add_noise();
		int n;
		logic [7:0] b;
		n = $urandom_range(1, 12);
		if ($urandom_range(0, 2) == 0)
			add_text("HTT");
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			tx_bytes.push_back(b);
		end
	endtask

	task automatic add_response(input bit long_body);
		int         body_len;
		int         clen;
		int         pick;
		logic [7:0] b;
		add_text("HTTP/1.1 ");
		if ($urandom_range(0, 9) < 8) begin
			add_text("20");
		end else begin
			add_text($urandom_range(0, 1) ? "40" : "21");
		end
		b = hrbf_pkg::CH_0 + 8'($urandom_range(0, 9));
		tx_bytes.push_back(b);
		if ($urandom_range(0, 9) == 0) begin
			add_crlf();
			add_text("Length: ");
		end else begin
			add_text(" OK");
			add_crlf();
			add_text("Content-Length: ");
		end
		body_len = long_body ? $urandom_range(48, 96) : $urandom_range(0, 12);
		pick = $urandom_range(0, 9);
		if (long_body)
			clen = body_len + 1;
		else if (pick == 0)
			clen = 0;
		else if (pick == 1)
			clen = $urandom_range(65536, 999999);
		else if (pick == 2)
			clen = 65535;
		else if (pick < 5)
			clen = body_len + 1 + $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
		else
			clen = body_len + 1;
		if (clen < 0)
			clen = 0;
		add_text($sformatf("%0d", clen));
		add_crlf();
		if ($urandom_range(0, 2) == 0) begin
			add_text("Server: 42");
			add_crlf();
		end
		add_crlf();
		repeat (body_len) begin
			b = 8'($urandom_range(0, 255));
			if (b == hrbf_pkg::CH_RBRACE)
				b = b ^ 8'h01;
			tx_bytes.push_back(b);
		end
		tx_bytes.push_back(hrbf_pkg::CH_RBRACE);
		if ($urandom_range(0, 3) == 0)
			add_crlf();
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		burst_left--;
		bytes_sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic flush_bytes();
		while (tx_bytes.size() > 0) begin
			send_byte(tx_bytes.pop_front());
		end
	endtask

	initial begin
		int  pick;
		int  cut;
		bit  long_done;
		long_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		add_text("HTTPHTTP");
		add_text("HTTP/1.1 404");
		add_crlf();
		flush_bytes();

		while (bytes_sent < TARGET_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				add_response(!long_done && bytes_sent > 250);
				if (bytes_sent > 250)
					long_done = 1'b1;
				if (pick >= 6) begin
					cut = $urandom_range(1, tx_bytes.size() - 1);
					repeat (cut) void'(tx_bytes.pop_back());
				end
			end else begin
				add_noise();
			end
			flush_bytes();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[http_response_body_framer_unit] OK");
		else
			$display("[http_response_body_framer_unit] ERROR");
		$finish;
	end

	initial begin
		int mode      = 0;
		int mode_left = 0;
		bit held      = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && bytes_sent >= 150) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= !m_tready;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[http_response_body_framer_unit] ERROR");
				$finish;
			end
		end
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/hrbf_pkg.sv
rtl/core/hrbf_window.sv
rtl/core/hrbf_parser.sv
rtl/core/http_response_body_framer_unit.sv
dv/hrbf_checker.sv
dv/testbench.sv
